/* hw/rtl/ubx_fp_pkg.sv */
// ----------------------------------------------------------------------------
// ubx_fp_pkg
// Shared constants, types and codes of the ubx frame parser.
// ----------------------------------------------------------------------------
package ubx_fp_pkg;

  localparam int unsigned PAYLOAD_BYTES = 200;
  localparam int unsigned STORE_WORDS   = (PAYLOAD_BYTES + 3) / 4;
  localparam int unsigned WORD_AW       = $clog2(STORE_WORDS);
  localparam int unsigned CNT_W         = $clog2(PAYLOAD_BYTES + 1);

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [7:0] ID_POSLLH = 8'h02;
  localparam logic [7:0] ID_STATUS = 8'h03;
  localparam logic [7:0] ID_SOL    = 8'h06;
  localparam logic [7:0] ID_VELNED = 8'h12;
  localparam logic [7:0] ID_SVINFO = 8'h30;

  // word addresses of the payload fields (payload byte offset / 4)
  localparam logic [WORD_AW-1:0] WA_LON    = WORD_AW'(4 / 4);
  localparam logic [WORD_AW-1:0] WA_LAT    = WORD_AW'(8 / 4);
  localparam logic [WORD_AW-1:0] WA_HGT    = WORD_AW'(16 / 4);
  localparam logic [WORD_AW-1:0] WA_SPD    = WORD_AW'(20 / 4);
  localparam logic [WORD_AW-1:0] WA_HDG    = WORD_AW'(24 / 4);
  localparam logic [WORD_AW-1:0] WA_STATUS = WORD_AW'(4 / 4);
  localparam logic [WORD_AW-1:0] WA_SOL    = WORD_AW'(44 / 4);

  // exact reciprocals for unsigned 32-bit dividends
  localparam logic [31:0] RECIP_1000   = 32'h10624DD3;
  localparam int unsigned SHIFT_1000   = 38;
  localparam logic [31:0] RECIP_10000  = 32'hD1B71759;
  localparam int unsigned SHIFT_10000  = 45;

  localparam int unsigned ALT_W = 23;
  localparam int unsigned CRS_W = 16;

  typedef enum logic [3:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CK_A,
    PH_CK_B
  } ubx_fp_phase_t;

  typedef enum logic [1:0] {
    DEC_IDLE,
    DEC_READ,
    DEC_MUL,
    DEC_DONE
  } ubx_fp_dec_t;

  typedef struct packed {
    logic               en;
    logic [WORD_AW-1:0] addr;
    logic [1:0]         lane;
    logic [7:0]         data;
  } ubx_fp_wr_t;

  typedef struct packed {
    logic       done;
    logic [7:0] id;
  } ubx_fp_frame_t;

  typedef struct packed {
    logic running;
    logic busy;
  } ubx_fp_status_t;

endpackage

/* hw/rtl/ubx_fp_store.sv */
// ----------------------------------------------------------------------------
// ubx_fp_store
// Payload store: 32-bit words with byte-lane writes, registered word read.
// ----------------------------------------------------------------------------
module ubx_fp_store (
  input  logic                         clk,
  input  ubx_fp_pkg::ubx_fp_wr_t       wr,
  input  logic [ubx_fp_pkg::WORD_AW-1:0] rd_addr,
  output logic [31:0]                  rd_data
);
  import ubx_fp_pkg::*;

  logic [3:0][7:0] mem [STORE_WORDS];
  logic [31:0]     rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr][wr.lane] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/ubx_fp_parser.sv */
// ----------------------------------------------------------------------------
// ubx_fp_parser
// Byte-level frame state machine: sync, header, payload write, fletcher check.
// ----------------------------------------------------------------------------
module ubx_fp_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_rx_byte,
  input  logic                      dec_busy,
  output ubx_fp_pkg::ubx_fp_wr_t    wr,
  output ubx_fp_pkg::ubx_fp_frame_t frame
);
  import ubx_fp_pkg::*;

  ubx_fp_phase_t    phase_r, phase_nxt;
  logic [7:0]       sum_a_r, sum_b_r;
  logic [7:0]       id_r;
  logic [7:0]       len_lo_r;
  logic [CNT_W-1:0] len_r;
  logic [CNT_W-1:0] cnt_r;

  logic             accept;
  logic [15:0]      len_full;
  logic [CNT_W-1:0] cnt_inc;
  logic [7:0]       sum_a_add, sum_b_add;

  // the last check byte waits until the decoder and result register are free
  assign in_ready  = !((phase_r == PH_CK_B) && dec_busy);
  assign accept    = in_valid && in_ready;
  assign len_full  = {in_rx_byte, len_lo_r};
  assign cnt_inc   = cnt_r + 1'b1;
  assign sum_a_add = sum_a_r + in_rx_byte;
  assign sum_b_add = sum_b_r + sum_a_add;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        PH_SYNC1:   phase_nxt = (in_rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
        PH_SYNC2:   phase_nxt = (in_rx_byte == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
        PH_CLASS:   phase_nxt = PH_ID;
        PH_ID:      phase_nxt = PH_LEN_LO;
        PH_LEN_LO:  phase_nxt = PH_LEN_HI;
        PH_LEN_HI: begin
          if (len_full > 16'(PAYLOAD_BYTES)) begin
            phase_nxt = PH_SYNC1;
          end else if (len_full == 16'd0) begin
            phase_nxt = PH_CK_A;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: phase_nxt = (cnt_inc >= len_r) ? PH_CK_A : PH_PAYLOAD;
        PH_CK_A:    phase_nxt = (in_rx_byte == sum_a_r) ? PH_CK_B : PH_SYNC1;
        PH_CK_B:    phase_nxt = PH_SYNC1;
        default:    phase_nxt = PH_SYNC1;
      endcase
    end
  end

  // outputs
  always_comb begin
    wr.en      = accept && (phase_r == PH_PAYLOAD);
    wr.addr    = cnt_r[2 +: WORD_AW];
    wr.lane    = cnt_r[1:0];
    wr.data    = in_rx_byte;
    frame.done = accept && (phase_r == PH_CK_B) && (in_rx_byte == sum_b_r);
    frame.id   = id_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      cnt_r   <= '0;
      len_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      if (accept && (phase_r == PH_LEN_HI)) begin
        cnt_r <= '0;
        len_r <= (len_full > 16'(PAYLOAD_BYTES)) ? '0 : len_full[CNT_W-1:0];
      end else if (accept && (phase_r == PH_PAYLOAD)) begin
        cnt_r <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (phase_r)
        PH_CLASS: begin
          sum_a_r <= in_rx_byte;
          sum_b_r <= in_rx_byte;
        end
        PH_ID: begin
          sum_a_r <= sum_a_add;
          sum_b_r <= sum_b_add;
          id_r    <= in_rx_byte;
        end
        PH_LEN_LO: begin
          sum_a_r  <= sum_a_add;
          sum_b_r  <= sum_b_add;
          len_lo_r <= in_rx_byte;
        end
        PH_LEN_HI, PH_PAYLOAD: begin
          sum_a_r <= sum_a_add;
          sum_b_r <= sum_b_add;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* hw/rtl/ubx_fp_decode.sv */
// ----------------------------------------------------------------------------
// ubx_fp_decode
// Reads the payload fields of a checked frame, scales them, updates the
// navigation record and holds the result until it is taken.
// ----------------------------------------------------------------------------
module ubx_fp_decode (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ubx_fp_pkg::ubx_fp_frame_t      frame,
  output logic [ubx_fp_pkg::WORD_AW-1:0] rd_addr,
  input  logic [31:0]                    rd_data,
  output ubx_fp_pkg::ubx_fp_status_t     status,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_message_id,
  output logic                           out_known_message,
  output logic signed [31:0]             out_longitude,
  output logic signed [31:0]             out_latitude,
  output logic signed [22:0]             out_altitude_m,
  output logic [7:0]                     out_fix_kind,
  output logic [7:0]                     out_satellites_used,
  output logic [31:0]                    out_ground_speed,
  output logic [15:0]                    out_heading,
  output logic                           out_fresh_fix
);
  import ubx_fp_pkg::*;

  ubx_fp_dec_t      state_r, state_nxt;
  logic [1:0]       step_r;
  logic [7:0]       id_r;
  logic [31:0]      w_r [3];
  logic [63:0]      prod_r;
  logic             neg_r;

  logic [31:0]      lon_r, lat_r, spd_r;
  logic [ALT_W-1:0] alt_r;
  logic [CRS_W-1:0] crs_r;
  logic [7:0]       fix_r, sats_r;
  logic             pmark_r, smark_r;
  logic             known_r, fresh_r, out_valid_r;

  logic             cap_en;
  logic [1:0]       cap_idx;
  logic             is_pos, is_vel, is_sts, is_sol, known;
  logic [31:0]      div_src, mag, recip;
  logic [ALT_W-1:0] q_alt, alt_val;
  logic [CRS_W-1:0] q_crs, crs_val;
  logic             pm_n, sm_n, fresh;

  assign is_pos = (id_r == ID_POSLLH);
  assign is_vel = (id_r == ID_VELNED);
  assign is_sts = (id_r == ID_STATUS);
  assign is_sol = (id_r == ID_SOL);
  assign known  = is_pos || is_vel || is_sts || is_sol || (id_r == ID_SVINFO);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DEC_IDLE: if (frame.done) state_nxt = DEC_READ;
      DEC_READ: if (step_r == 2'd3) state_nxt = DEC_MUL;
      DEC_MUL:  state_nxt = DEC_DONE;
      DEC_DONE: state_nxt = DEC_IDLE;
      default:  state_nxt = DEC_IDLE;
    endcase
  end

  // outputs: read address per step, capture of the previous read
  always_comb begin
    cap_en  = (state_r == DEC_READ) && (step_r != 2'd0);
    cap_idx = step_r - 2'd1;
    rd_addr = WA_LON;
    priority if (is_pos) begin
      rd_addr = (step_r == 2'd0) ? WA_LON : ((step_r == 2'd1) ? WA_LAT : WA_HGT);
    end else if (is_vel) begin
      rd_addr = (step_r == 2'd0) ? WA_SPD : WA_HDG;
    end else if (is_sts) begin
      rd_addr = WA_STATUS;
    end else if (is_sol) begin
      rd_addr = WA_SOL;
    end else begin
      rd_addr = WA_LON;
    end
  end

  // signed truncating division by a constant: magnitude times reciprocal
  assign div_src = is_pos ? w_r[2] : w_r[1];
  assign mag     = div_src[31] ? (32'd0 - div_src) : div_src;
  assign recip   = is_pos ? RECIP_1000 : RECIP_10000;
  assign q_alt   = prod_r[SHIFT_1000 +: ALT_W];
  assign q_crs   = prod_r[SHIFT_10000 +: CRS_W];
  assign alt_val = neg_r ? (ALT_W'(0) - q_alt) : q_alt;
  assign crs_val = neg_r ? (CRS_W'(0) - q_crs) : q_crs;

  assign pm_n  = pmark_r || is_pos;
  assign sm_n  = smark_r || is_vel;
  assign fresh = known && pm_n && sm_n;

  always_ff @(posedge clk) begin
    if (frame.done && (state_r == DEC_IDLE)) begin
      id_r <= frame.id;
    end
    if (cap_en) begin
      w_r[cap_idx] <= rd_data;
    end
    if (state_r == DEC_MUL) begin
      prod_r <= 64'(mag) * 64'(recip);
      neg_r  <= div_src[31];
    end
    if (state_r == DEC_DONE) begin
      known_r <= known;
      fresh_r <= fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= DEC_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      lon_r       <= '0;
      lat_r       <= '0;
      alt_r       <= '0;
      spd_r       <= '0;
      crs_r       <= '0;
      fix_r       <= '0;
      sats_r      <= '0;
      pmark_r     <= 1'b0;
      smark_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= (state_r == DEC_READ) ? step_r + 2'd1 : 2'd0;
      if (state_r == DEC_DONE) begin
        out_valid_r <= 1'b1;
        if (is_pos) begin
          lon_r <= w_r[0];
          lat_r <= w_r[1];
          alt_r <= alt_val;
        end
        if (is_vel) begin
          spd_r <= w_r[0];
          crs_r <= crs_val;
        end
        if (is_sts) begin
          fix_r <= w_r[0][7:0];
        end
        if (is_sol) begin
          sats_r <= w_r[0][31:24];
        end
        if (known) begin
          pmark_r <= fresh ? 1'b0 : pm_n;
          smark_r <= fresh ? 1'b0 : sm_n;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.running = (state_r != DEC_IDLE);
  assign status.busy    = (state_r != DEC_IDLE) || out_valid_r;

  // record stays put while a result waits, so it drives the result directly
  assign out_valid           = out_valid_r;
  assign out_message_id      = id_r;
  assign out_known_message   = known_r;
  assign out_longitude       = lon_r;
  assign out_latitude        = lat_r;
  assign out_altitude_m      = alt_r;
  assign out_fix_kind        = fix_r;
  assign out_satellites_used = sats_r;
  assign out_ground_speed    = spd_r;
  assign out_heading         = crs_r;
  assign out_fresh_fix       = fresh_r;

endmodule

/* hw/rtl/ubx_frame_parser_top.sv */
// ----------------------------------------------------------------------------
// ubx_frame_parser_top
// UBX byte stream parser with fletcher check and navigation record update.
// ----------------------------------------------------------------------------
// one received byte per cycle; out_valid rises after the second check byte
// of a good frame is accepted, once the payload store reads and captures,
// the reciprocal multiply and the record update are done.
// the second check byte is held off while an earlier frame is decoding or
// its result is not yet taken; all other bytes flow at one per cycle.
// synchronous reset clears the parser, decoder and record; the payload store
// is not cleared.
module ubx_frame_parser_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_message_id,
  output logic               out_known_message,
  output logic signed [31:0] out_longitude,
  output logic signed [31:0] out_latitude,
  output logic signed [22:0] out_altitude_m,
  output logic [7:0]         out_fix_kind,
  output logic [7:0]         out_satellites_used,
  output logic [31:0]        out_ground_speed,
  output logic [15:0]        out_heading,
  output logic               out_fresh_fix
);
  import ubx_fp_pkg::*;

  ubx_fp_wr_t         wr;
  ubx_fp_frame_t      frame;
  ubx_fp_status_t     status;
  logic [WORD_AW-1:0] rd_addr;
  logic [31:0]        rd_data;

  ubx_fp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .dec_busy   (status.busy),
    .wr         (wr),
    .frame      (frame)
  );

  ubx_fp_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ubx_fp_decode u_decode (
    .clk                 (clk),
    .rst_n               (rst_n),
    .frame               (frame),
    .rd_addr             (rd_addr),
    .rd_data             (rd_data),
    .status              (status),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_message_id      (out_message_id),
    .out_known_message   (out_known_message),
    .out_longitude       (out_longitude),
    .out_latitude        (out_latitude),
    .out_altitude_m      (out_altitude_m),
    .out_fix_kind        (out_fix_kind),
    .out_satellites_used (out_satellites_used),
    .out_ground_speed    (out_ground_speed),
    .out_heading         (out_heading),
    .out_fresh_fix       (out_fresh_fix)
  );

  // a checked frame always produces a result
  a_frame_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    frame.done |-> ##7 out_valid)
    else $error("checked frame did not produce a result");

  // decode never runs while a result is still held
  a_decode_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    status.running |-> !out_valid)
    else $error("decode running while a result waits");

  // a new frame is never checked while the decoder is busy
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    frame.done |-> !status.busy)
    else $error("frame completed while decoder busy");

  // fresh fix only on a recognised message
  a_fresh_known: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fresh_fix) |-> out_known_message)
    else $error("fresh fix on unknown message");

endmodule
